>>> rtl/sasc_pkg.sv
// Shared widths, constants and register codes for the slope angle averaging unit.
// No dependencies; imported by the top level, by its port checker and by the bench.

package sasc_pkg;

   localparam int FRAC_BITS = 7;
   localparam int LANES     = 4;

   localparam int SLOPE_W = 15;
   localparam int HEAD_W  = 16;
   localparam int FLAT_W  = 14;
   localparam int LIMIT_W = 14;
   localparam int WRAP_W  = 15;

   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // offset of the first heading field in the request beat
   localparam int HEAD_BASE = LANES * SLOPE_W;

   // half a turn in fixed point, on the width of the reflected heading sums
   localparam logic signed [17:0] HALF_TURN = 18'(180 << FRAC_BITS);

   localparam logic [FLAT_W-1:0]  FLAT_RESET  = FLAT_W'(640);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);
   localparam logic [WRAP_W-1:0]  WRAP_RESET  = WRAP_W'(11520);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLAT_THRESHOLD        = 2'd0,
      CSR_SLOPE_SPREAD_LIMIT    = 2'd1,
      CSR_WRAP_SPREAD_THRESHOLD = 2'd2
   } csr_index_type;

endpackage

>>> rtl/slope_angle_average_with_spread_check_unit.sv
// Slope angle averaging with slope spread check and wrap-aware heading mean.
// Depends on sasc_pkg for field widths, register codes and the half-turn constant.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------
//  req     | in  | req_tvalid/req_tready  | req_tdata: 4 slopes, 4 headings
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: mean slope, mean heading;
//          |     |                        | rsp_tuser: outlier
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// One beat per cycle in and out while the rsp side takes results; a result passes the input
// register, the square/sum register and the result register in turn.
// A stall from the rsp side backs up stage by stage; an empty stage still takes a beat.
// The lane squarers and the sum-squared multipliers set the stage-two path.
// reset (synchronous) empties the pipeline and loads the register defaults.
// csr_ready is always high; a write to an unused index is dropped.

module slope_angle_average_with_spread_check_unit
   import sasc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // slope_a, slope_b, slope_c, slope_d (15b each),
   // heading_a, heading_b, heading_c, heading_d (16b each), 4 zero bits
   input  logic [REQ_DATA_W-1:0]  req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // mean_slope (15b), mean_heading (16b), 1 zero bit
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // outlier (1b)
   output logic [RSP_USER_W-1:0]  rsp_tuser,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration
   logic [FLAT_W-1:0]  flat_ff,  flat_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [WRAP_W-1:0]  wrap_ff,  wrap_in;

   // stall chain
   logic out_adv, b_adv, a_adv;

   // stage A: input register
   logic                     a_vld_ff, a_vld_in;
   logic signed [SLOPE_W-1:0] a_slope_ff [LANES];
   logic signed [SLOPE_W-1:0] a_slope_in [LANES];
   logic signed [HEAD_W-1:0]  a_head_ff  [LANES];
   logic signed [HEAD_W-1:0]  a_head_in  [LANES];

   // stage B: squares and sums
   logic               b_vld_ff, b_vld_in;
   logic signed [16:0] b_s_sum_ff, b_s_sum_in;
   logic signed [17:0] b_h_sum_ff, b_h_sum_in;
   logic signed [17:0] b_r_sum_ff, b_r_sum_in;
   logic [28:0]        b_s_sq_ff [LANES];
   logic [28:0]        b_s_sq_in [LANES];
   logic [30:0]        b_h_sq_ff [LANES];
   logic [30:0]        b_h_sq_in [LANES];
   logic [32:0]        b_s_sum_sq_ff, b_s_sum_sq_in;
   logic [34:0]        b_h_sum_sq_ff, b_h_sum_sq_in;
   logic [27:0]        b_lim_sq_ff, b_lim_sq_in;
   logic [29:0]        b_wrap_sq_ff, b_wrap_sq_in;

   // stage C: result register
   logic                      rsp_vld_ff, rsp_vld_in;
   logic signed [SLOPE_W-1:0] rsp_slope_ff, rsp_slope_in;
   logic signed [HEAD_W-1:0]  rsp_head_ff,  rsp_head_in;
   logic                      rsp_outlier_ff, rsp_outlier_in;

   // stage C working values
   logic signed [SLOPE_W-1:0] mean_slope;
   logic                      is_flat;
   logic [30:0]               s_q;
   logic [33:0]               s_spread;
   logic                      is_outlier;
   logic [32:0]               h_q;
   logic [34:0]               h_spread;
   logic                      use_wrap;
   logic signed [17:0]        r_mean;
   logic signed [HEAD_W-1:0]  h_mean;

   assign out_adv    = !rsp_vld_ff || rsp_tready;
   assign b_adv      = !b_vld_ff || out_adv;
   assign a_adv      = !a_vld_ff || b_adv;
   assign req_tready = a_adv;
   assign csr_ready  = 1'b1;

   // ---------------- configuration registers ----------------
   always_comb begin
      flat_in  = flat_ff;
      limit_in = limit_ff;
      wrap_in  = wrap_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FLAT_THRESHOLD:        flat_in  = csr_data[FLAT_W-1:0];
            CSR_SLOPE_SPREAD_LIMIT:    limit_in = csr_data[LIMIT_W-1:0];
            CSR_WRAP_SPREAD_THRESHOLD: wrap_in  = csr_data[WRAP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage A ----------------
   always_comb begin
      a_vld_in = a_adv ? req_tvalid : a_vld_ff;
      for (int i = 0; i < LANES; i++) begin
         a_slope_in[i] = a_adv ? $signed(req_tdata[i*SLOPE_W +: SLOPE_W]) : a_slope_ff[i];
         a_head_in[i]  = a_adv ? $signed(req_tdata[HEAD_BASE + i*HEAD_W +: HEAD_W])
                               : a_head_ff[i];
      end
   end

   // ---------------- stage B ----------------
   always_comb begin
      logic signed [16:0] s_sum;
      logic signed [17:0] h_sum;
      logic signed [17:0] r_sum;
      logic signed [17:0] h_ext;
      logic signed [29:0] s_prod;
      logic signed [31:0] h_prod;
      logic signed [33:0] s_sum_prod;
      logic signed [35:0] h_sum_prod;
      s_sum = '0;
      h_sum = '0;
      r_sum = '0;
      b_vld_in = b_adv ? a_vld_ff : b_vld_ff;
      for (int i = 0; i < LANES; i++) begin
         h_ext  = 18'(a_head_ff[i]);
         s_sum  = s_sum + 17'(a_slope_ff[i]);
         h_sum  = h_sum + h_ext;
         // reflect about the half turn on the side of the reading's sign
         r_sum  = r_sum + (h_ext[17] ? (-HALF_TURN - h_ext) : (HALF_TURN - h_ext));
         s_prod = 30'(a_slope_ff[i]) * 30'(a_slope_ff[i]);
         h_prod = 32'(a_head_ff[i]) * 32'(a_head_ff[i]);
         b_s_sq_in[i] = b_adv ? s_prod[28:0] : b_s_sq_ff[i];
         b_h_sq_in[i] = b_adv ? h_prod[30:0] : b_h_sq_ff[i];
      end
      s_sum_prod = 34'(s_sum) * 34'(s_sum);
      h_sum_prod = 36'(h_sum) * 36'(h_sum);
      if (b_adv) begin
         b_s_sum_in    = s_sum;
         b_h_sum_in    = h_sum;
         b_r_sum_in    = r_sum;
         b_s_sum_sq_in = s_sum_prod[32:0];
         b_h_sum_sq_in = h_sum_prod[34:0];
         b_lim_sq_in   = 28'(limit_ff) * 28'(limit_ff);
         b_wrap_sq_in  = 30'(wrap_ff) * 30'(wrap_ff);
      end else begin
         b_s_sum_in    = b_s_sum_ff;
         b_h_sum_in    = b_h_sum_ff;
         b_r_sum_in    = b_r_sum_ff;
         b_s_sum_sq_in = b_s_sum_sq_ff;
         b_h_sum_sq_in = b_h_sum_sq_ff;
         b_lim_sq_in   = b_lim_sq_ff;
         b_wrap_sq_in  = b_wrap_sq_ff;
      end
   end

   // ---------------- stage C ----------------
   always_comb begin
      // divide by four rounding down: drop the two low bits
      mean_slope = b_s_sum_ff[16:2];
      is_flat    = $signed({mean_slope[SLOPE_W-1], mean_slope}) < $signed({2'b00, flat_ff});

      s_q = '0;
      h_q = '0;
      for (int i = 0; i < LANES; i++) begin
         s_q = s_q + 31'(b_s_sq_ff[i]);
         h_q = h_q + 33'(b_h_sq_ff[i]);
      end
      // 4*Q - S*S is never negative
      s_spread   = {1'b0, s_q, 2'b00} - 34'(b_s_sum_sq_ff);
      is_outlier = s_spread >= {2'b00, b_lim_sq_ff, 4'b0000};
      h_spread   = {h_q, 2'b00} - b_h_sum_sq_ff;
      use_wrap   = h_spread > {1'b0, b_wrap_sq_ff, 4'b0000};

      r_mean = b_r_sum_ff >>> 2;
      if (use_wrap) begin
         h_mean = r_mean[17] ? HEAD_W'(-HALF_TURN - r_mean) : HEAD_W'(HALF_TURN - r_mean);
      end else begin
         h_mean = b_h_sum_ff[17:2];
      end

      rsp_vld_in     = out_adv ? b_vld_ff : rsp_vld_ff;
      rsp_slope_in   = rsp_slope_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_outlier_in = rsp_outlier_ff;
      if (out_adv) begin
         if (is_flat) begin
            rsp_slope_in   = mean_slope;
            rsp_head_in    = '0;
            rsp_outlier_in = 1'b0;
         end else if (is_outlier) begin
            rsp_slope_in   = '0;
            rsp_head_in    = '0;
            rsp_outlier_in = 1'b1;
         end else begin
            rsp_slope_in   = mean_slope;
            rsp_head_in    = h_mean;
            rsp_outlier_in = 1'b0;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         flat_ff    <= FLAT_RESET;
         limit_ff   <= LIMIT_RESET;
         wrap_ff    <= WRAP_RESET;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         flat_ff    <= flat_in;
         limit_ff   <= limit_in;
         wrap_ff    <= wrap_in;
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         a_slope_ff[i] <= a_slope_in[i];
         a_head_ff[i]  <= a_head_in[i];
         b_s_sq_ff[i]  <= b_s_sq_in[i];
         b_h_sq_ff[i]  <= b_h_sq_in[i];
      end
      b_s_sum_ff     <= b_s_sum_in;
      b_h_sum_ff     <= b_h_sum_in;
      b_r_sum_ff     <= b_r_sum_in;
      b_s_sum_sq_ff  <= b_s_sum_sq_in;
      b_h_sum_sq_ff  <= b_h_sum_sq_in;
      b_lim_sq_ff    <= b_lim_sq_in;
      b_wrap_sq_ff   <= b_wrap_sq_in;
      rsp_slope_ff   <= rsp_slope_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_outlier_ff <= rsp_outlier_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_head_ff, rsp_slope_ff};
   assign rsp_tuser  = rsp_outlier_ff;

endmodule

>>> rtl/sasc_check.sv
// Port-level checks for the slope angle averaging unit, bound to the top level.
// Depends on sasc_pkg for port widths.

module sasc_check
   import sasc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic [RSP_USER_W-1:0]  rsp_tuser,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // a rejected set carries zero mean slope and zero heading
   a_outlier_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("outlier beat with nonzero data");

   // the request side backs up only when every stage holds a beat the rsp side refuses
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low while the result side drains");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // a refused result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // padding bit and configuration ready
   a_pad_ready: assert property (@(posedge clock) disable iff (reset)
      (csr_valid || req_tvalid) |-> csr_ready && (rsp_tdata[RSP_DATA_W-1] == 1'b0))
      else $error("csr_ready low or padding bit set");

endmodule

bind slope_angle_average_with_spread_check_unit sasc_check u_sasc_check (.*);

>>> dv/tb_top.sv
// Self-checking bench for slope_angle_average_with_spread_check_unit: drives reading sets,
// predicts each mean slope, mean heading and outlier flag, and compares them beat by beat.
// Depends on sasc_pkg for field widths, reset values and register codes.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sasc_pkg::*;

   localparam int  HALF_TURN_FX    = 180 << FRAC_BITS;
   localparam int  FULL_TURN_FX    = 2 * HALF_TURN_FX;
   localparam int  SLOPE_SPAN      = 90 << FRAC_BITS;
   localparam int  RSP_HOLD_CYCLES = 300;
   localparam int  IDLE_LIMIT      = 4000;
   localparam int  SETTLE_CYCLES   = 4;
   localparam int  DRAIN_CYCLES    = 8;
   localparam int  PHASES          = 8;
   localparam int  PHASE_ITEMS     = 200;
   localparam int  PRESSURE_ITEMS  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct {
      logic signed [SLOPE_W-1:0] slope [LANES];
      logic signed [HEAD_W-1:0]  heading [LANES];
   } reading_set_type;

   typedef struct {
      logic signed [SLOPE_W-1:0] mean_slope;
      logic signed [HEAD_W-1:0]  mean_heading;
      logic                      outlier;
   } tilt_result_type;

   class tilt_scoreboard;
      tilt_result_type tilt_q[$];
      int flat_thr;
      int spread_lim;
      int wrap_thr;
      int errors;

      function new();
         flat_thr   = FLAT_RESET;
         spread_lim = LIMIT_RESET;
         wrap_thr   = WRAP_RESET;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_FLAT_THRESHOLD:        flat_thr   = int'(val[FLAT_W-1:0]);
            CSR_SLOPE_SPREAD_LIMIT:    spread_lim = int'(val[LIMIT_W-1:0]);
            CSR_WRAP_SPREAD_THRESHOLD: wrap_thr   = int'(val[WRAP_W-1:0]);
            default: ;
         endcase
      endfunction

      // mirror a heading about the +-180 degree line
      function longint mirror_half_turn(longint v);
         return (v < 0) ? (-HALF_TURN_FX - v) : (HALF_TURN_FX - v);
      endfunction

      // 4*sum(x^2) - (sum x)^2, i.e. sixteen times the variance of the four lanes
      function longint quad_spread(longint a, longint b, longint c, longint d);
         longint s;
         longint q;
         s = a + b + c + d;
         q = a * a + b * b + c * c + d * d;
         return 4 * q - s * s;
      endfunction

      function tilt_result_type predict_tilt(reading_set_type r);
         longint sl [LANES];
         longint hd [LANES];
         longint s, hs, rs, mean, hmean, lim, wrp;
         tilt_result_type res;
         s  = 0;
         hs = 0;
         rs = 0;
         for (int i = 0; i < LANES; i++) begin
            sl[i] = r.slope[i];
            hd[i] = r.heading[i];
            s  += sl[i];
            hs += hd[i];
            rs += mirror_half_turn(hd[i]);
         end
         res.mean_slope   = '0;
         res.mean_heading = '0;
         res.outlier      = 1'b0;
         mean = s >>> 2;
         if (mean < flat_thr) begin
            res.mean_slope = mean[SLOPE_W-1:0];
            return res;
         end
         lim = spread_lim;
         if (quad_spread(sl[0], sl[1], sl[2], sl[3]) >= 16 * lim * lim) begin
            res.outlier = 1'b1;
            return res;
         end
         wrp = wrap_thr;
         if (quad_spread(hd[0], hd[1], hd[2], hd[3]) > 16 * wrp * wrp)
            hmean = mirror_half_turn(rs >>> 2);
         else
            hmean = hs >>> 2;
         res.mean_slope   = mean[SLOPE_W-1:0];
         res.mean_heading = hmean[HEAD_W-1:0];
         return res;
      endfunction

      function void note_request(logic [REQ_DATA_W-1:0] d);
         reading_set_type r;
         for (int i = 0; i < LANES; i++) begin
            r.slope[i]   = d[i*SLOPE_W +: SLOPE_W];
            r.heading[i] = d[HEAD_BASE + i*HEAD_W +: HEAD_W];
         end
         tilt_q.push_back(predict_tilt(r));
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d, logic [RSP_USER_W-1:0] u);
         tilt_result_type want;
         logic signed [SLOPE_W-1:0] got_slope;
         logic signed [HEAD_W-1:0]  got_heading;
         got_slope   = d[SLOPE_W-1:0];
         got_heading = d[SLOPE_W +: HEAD_W];
         if (tilt_q.size() == 0) begin
            $display("%0t ERROR expected none, got slope %0d heading %0d outlier %0d",
                     $time, got_slope, got_heading, u[0]);
            errors++;
            return;
         end
         want = tilt_q.pop_front();
         if (got_slope !== want.mean_slope) begin
            $display("%0t ERROR mean_slope: expected %0d, got %0d",
                     $time, want.mean_slope, got_slope);
            errors++;
         end
         if (got_heading !== want.mean_heading) begin
            $display("%0t ERROR mean_heading: expected %0d, got %0d",
                     $time, want.mean_heading, got_heading);
            errors++;
         end
         if (u[0] !== want.outlier) begin
            $display("%0t ERROR outlier: expected %0d, got %0d", $time, want.outlier, u[0]);
            errors++;
         end
      endfunction

      function int queued();
         return tilt_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   tilt_scoreboard sb = new();
   bit hold_rsp   = 1'b0;
   bit rsp_steady = 1'b0;
   int idle_cycles = 0;

   slope_angle_average_with_spread_check_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
                                        : int'($urandom_range(10, 40));
   endfunction

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic reading_set_type readings(int s0, int s1, int s2, int s3,
                                                int h0, int h1, int h2, int h3);
      reading_set_type r;
      r.slope[0]   = s0[SLOPE_W-1:0];
      r.slope[1]   = s1[SLOPE_W-1:0];
      r.slope[2]   = s2[SLOPE_W-1:0];
      r.slope[3]   = s3[SLOPE_W-1:0];
      r.heading[0] = h0[HEAD_W-1:0];
      r.heading[1] = h1[HEAD_W-1:0];
      r.heading[2] = h2[HEAD_W-1:0];
      r.heading[3] = h3[HEAD_W-1:0];
      return r;
   endfunction

   // mostly clustered sets, some with a slope spread inside the limit, the rest uniform or raw bits
   function automatic reading_set_type random_readings();
      reading_set_type r;
      int kind, base, sdev, hc, hdev, v;
      kind = $urandom_range(0, 99);
      base = rand_between(-2000, SLOPE_SPAN);
      sdev = (kind < 45) ? int'($urandom_range(0, sb.spread_lim / 2))
                         : int'($urandom_range(0, SLOPE_SPAN));
      hc   = rand_between(-HALF_TURN_FX, HALF_TURN_FX);
      hdev = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, HALF_TURN_FX))
                                         : int'($urandom_range(0, 3000));
      for (int i = 0; i < LANES; i++) begin
         if (kind < 60) begin
            v = base + rand_between(-sdev, sdev);
            if (v > SLOPE_SPAN) v = SLOPE_SPAN;
            if (v < -SLOPE_SPAN) v = -SLOPE_SPAN;
            r.slope[i] = v[SLOPE_W-1:0];
            v = hc + rand_between(-hdev, hdev);
            if (v > HALF_TURN_FX) v -= FULL_TURN_FX;
            else if (v < -HALF_TURN_FX) v += FULL_TURN_FX;
            r.heading[i] = v[HEAD_W-1:0];
         end else if (kind < 80) begin
            v = rand_between(-SLOPE_SPAN, SLOPE_SPAN);
            r.slope[i] = v[SLOPE_W-1:0];
            v = rand_between(-HALF_TURN_FX, HALF_TURN_FX);
            r.heading[i] = v[HEAD_W-1:0];
         end else begin
            r.slope[i]   = SLOPE_W'($urandom);
            r.heading[i] = HEAD_W'($urandom);
         end
      end
      return r;
   endfunction

   // leaves tvalid high; the caller drops it when it idles
   task automatic send_readings(reading_set_type r);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      for (int i = 0; i < LANES; i++) begin
         d[i*SLOPE_W +: SLOPE_W]             = r.slope[i];
         d[HEAD_BASE + i*HEAD_W +: HEAD_W]   = r.heading[i];
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      while (sb.queued() != 0) @(posedge clock);
   endtask

   task automatic configure(int phase);
      logic [CSR_DATA_W-1:0] flat_v, lim_v, wrap_v;
      case (phase)
         0: begin flat_v = 16'd640;   lim_v = 16'd256;   wrap_v = 16'd11520; end
         1: begin flat_v = 16'd0;     lim_v = 16'd0;     wrap_v = 16'd0;     end
         2: begin flat_v = 16'd11520; lim_v = 16'd11520; wrap_v = 16'd23040; end
         3: begin flat_v = 16'hFFFF;  lim_v = 16'hFFFF;  wrap_v = 16'hFFFF;  end
         default: begin
            flat_v = CSR_DATA_W'($urandom_range(0, 11520));
            lim_v  = CSR_DATA_W'($urandom_range(0, 1500));
            wrap_v = CSR_DATA_W'($urandom_range(0, 23040));
         end
      endcase
      csr_write(CSR_FLAT_THRESHOLD, flat_v);
      csr_write(CSR_SLOPE_SPREAD_LIMIT, lim_v);
      csr_write(CSR_WRAP_SPREAD_THRESHOLD, wrap_v);
      if (phase == 3) csr_write(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic directed_items();
      send_readings(readings(0, 0, 0, 0, 0, 0, 0, 0));
      send_readings(readings(11520, 11520, 11520, 11520, 23040, 23040, 23040, 23040));
      send_readings(readings(-11520, -11520, -11520, -11520, -23040, -23040, -23040, -23040));
      send_readings(readings(16383, 16383, 16383, 16383, 32767, 32767, 32767, 32767));
      send_readings(readings(-16384, -16384, -16384, -16384, -32768, -32768, -32768, -32768));
      // mean right at the flat threshold, then one below it
      send_readings(readings(640, 640, 640, 640, 100, 200, 300, 400));
      send_readings(readings(639, 640, 640, 640, 100, 200, 300, 400));
      // slope spread exactly at the limit, then just inside it
      send_readings(readings(1256, 1256, 744, 744, 10, 20, 30, 40));
      send_readings(readings(1255, 1255, 745, 745, -1, 0, 0, 0));
      // heading spread exactly at the wrap threshold, then just over it
      send_readings(readings(2000, 2000, 2000, 2000, 11520, 11520, -11520, -11520));
      send_readings(readings(2000, 2000, 2000, 2000, 11521, 11521, -11521, -11521));
      send_readings(readings(3000, 3000, 3000, 3000, 23000, -23000, 22900, -22900));
      send_readings(readings(3000, 3001, 3002, 3003, -23040, 23040, -22000, 22500));
      send_readings(readings(-1, 0, 0, 0, 5, 6, 7, 8));
      send_readings(readings(1000, 3000, 1000, 3000, 0, 0, 0, 0));
      send_readings(readings(16383, -16384, 16383, -16384, 1, 2, 3, 4));
      send_readings(readings(2000, 2000, 2000, 2000, 32767, -32768, 32767, -32768));
      send_readings(readings(5000, 5001, 5002, 5003, 5, -7, 13, -2));
      req_tvalid <= 1'b0;
   endtask

   task automatic random_items(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 199) == 0) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait_for_results();
         end else if (((n / 40) % 3 != 0) && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
         send_readings(random_readings());
      end
      req_tvalid <= 1'b0;
   endtask

   // scoreboard taps: results are checked before the same edge's request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ERROR no beat accepted for %0d cycles", $time, IDLE_LIMIT);
         $display("FAIL slope_angle_average_with_spread_check_unit");
         $finish;
      end
   end

   // result side: random stalls, steady stretches, and one long hold on request
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (!rsp_steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      @(posedge clock);
      wait_for_results();

      // fill the pipeline against a stalled result side
      hold_rsp = 1'b1;
      for (int n = 0; n < PRESSURE_ITEMS; n++) send_readings(random_readings());
      req_tvalid <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         @(posedge clock);
         wait_for_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
         configure(phase);
         rsp_steady = (phase == 2 || phase == 5);
         random_items(PHASE_ITEMS);
      end

      @(posedge clock);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.queued() != 0) begin
         $display("%0t ERROR %0d results never arrived", $time, sb.queued());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("PASS slope_angle_average_with_spread_check_unit");
      else
         $display("FAIL slope_angle_average_with_spread_check_unit");
      $finish;
   end

endmodule
